// File: design/bam_pkg.sv
package bam_pkg;

  // Field and register widths.
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int BD_W       = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int GIDX_W     = 7;
  localparam int GCODE_W    = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ENABLE = 3'd4;

  // Register reset values.
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [BD_W-1:0] RST_BLOCK_WIDTH  = 7'd8;
  localparam logic [BD_W-1:0] RST_BLOCK_HEIGHT = 7'd16;

  // Default parameter values.
  localparam int DEF_MAX_FRAME_WIDTH = 1024;
  localparam int DEF_MAX_BLOCK_DIM   = 64;
  localparam int DEF_GLYPH_COUNT     = 70;

  // Accumulator and divider widths. A cell holds at most 127*127 pixels.
  localparam int CNT_W = 14;
  localparam int SUM_W = 22;
  localparam int NUM_W = 24;
  localparam int DEN_W = 15;
  localparam int WS_W  = 18;

  // floor(x/1000) = (x*LUMA_RECIP) >> LUMA_SHIFT for x below 255001.
  localparam int LUMA_RECIP = 268436;
  localparam int LUMA_SHIFT = 28;
  // floor(x/255) = (x*DIV255_RECIP) >> DIV255_SHIFT for x below 65536.
  localparam int DIV255_RECIP = 65794;
  localparam int DIV255_SHIFT = 24;

  localparam int RAMP_LEN = 70;
  localparam logic [8*RAMP_LEN-1:0] GLYPH_RAMP =
    " .'`^,:;Il!i><~+_-?][}{1)(|\\/tfjrxnumbroCLJVUNYXOZmwqpdbkhao*#MW&8%B@$";

  typedef struct packed {
    logic accept;
    logic read;
    logic add;
    logic div_start;
    logic div_step;
    logic map;
    logic load;
  } bam_cmd_t;

  typedef struct packed {
    logic keep_last;
    logic div_last;
    logic out_free;
  } bam_status_t;

  function automatic logic [GCODE_W-1:0] glyph_char(input logic [7:0] lut);
    logic [7:0] ch;
    ch = GLYPH_RAMP[8*(RAMP_LEN-1-int'(lut)) +: 8];
    return ch[GCODE_W-1:0];
  endfunction

endpackage

// File: design/bam_ctrl.sv
module bam_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bam_pkg::bam_status_t status,
  output bam_pkg::bam_cmd_t    cmd
);
  import bam_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MAP  = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (status.keep_last) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_MAP;
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/bam_datapath.sv
module bam_datapath #(
  parameter int MAX_FRAME_WIDTH = bam_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_BLOCK_DIM   = bam_pkg::DEF_MAX_BLOCK_DIM,
  parameter int GLYPH_COUNT     = bam_pkg::DEF_GLYPH_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bam_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [bam_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bam_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  input  bam_pkg::bam_cmd_t                 cmd,
  output bam_pkg::bam_status_t              status
);
  import bam_pkg::*;

  localparam int GX_W  = $clog2(MAX_FRAME_WIDTH);
  localparam int DC_W  = $clog2(NUM_W);
  localparam int MEM_W = 4 * SUM_W;

  // Configuration registers.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [BD_W-1:0] block_width, block_height;
  logic            color_enable;
  logic            restart;

  assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
                   cfg_index == REG_BLOCK_WIDTH || cfg_index == REG_BLOCK_HEIGHT ||
                   cfg_index == REG_COLOR_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      block_width  <= RST_BLOCK_WIDTH;
      block_height <= RST_BLOCK_HEIGHT;
      color_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BD_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= cfg_data[BD_W-1:0];
        REG_COLOR_ENABLE: color_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [BD_W-1:0] bw_s, bh_s;
  assign bw_s = (int'(block_width) > MAX_BLOCK_DIM) ? BD_W'(MAX_BLOCK_DIM) : block_width;
  assign bh_s = (int'(block_height) > MAX_BLOCK_DIM) ? BD_W'(MAX_BLOCK_DIM) : block_height;

  // Raster position, kept both as pixel coordinates and as grid cell plus offset.
  logic [FW_W-1:0] pos_x, gx;
  logic [FH_W-1:0] pos_y, gy;
  logic [BD_W-1:0] ox, oy;
  logic [19:0]     end_x;
  logic [21:0]     end_y;
  logic            x_wrap, y_wrap, in_x, in_y, keep_now, first_now, last_now, done_now;

  assign x_wrap = (12'(pos_x) + 12'd1) >= 12'(frame_width);
  assign y_wrap = (14'(pos_y) + 14'd1) >= 14'(frame_height);
  assign end_x  = (20'(gx) + 20'd1) * 20'(bw_s);
  assign end_y  = (22'(gy) + 22'd1) * 22'(bh_s);
  assign in_x   = (end_x <= 20'(frame_width)) && (int'(gx) < MAX_FRAME_WIDTH);
  assign in_y   = end_y <= 22'(frame_height);
  assign keep_now  = (bw_s != '0) && (bh_s != '0) && in_x && in_y;
  assign first_now = (ox == '0) && (oy == '0);
  assign last_now  = (ox + 7'd1 == bw_s) && (oy + 7'd1 == bh_s);
  assign done_now  = ((end_x + 20'(bw_s) > 20'(frame_width)) ||
                      (int'(gx) + 1 == MAX_FRAME_WIDTH)) &&
                     (end_y + 22'(bh_s) > 22'(frame_height));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_x <= '0;
      gx    <= '0;
      ox    <= '0;
      pos_y <= '0;
      gy    <= '0;
      oy    <= '0;
    end else if (cmd.accept) begin
      if (x_wrap) begin
        pos_x <= '0;
        gx    <= '0;
        ox    <= '0;
        if (y_wrap) begin
          pos_y <= '0;
          gy    <= '0;
          oy    <= '0;
        end else begin
          pos_y <= pos_y + 13'd1;
          if (oy + 7'd1 == bh_s) begin
            oy <= '0;
            gy <= gy + 13'd1;
          end else begin
            oy <= oy + 7'd1;
          end
        end
      end else begin
        pos_x <= pos_x + 11'd1;
        if (ox + 7'd1 == bw_s) begin
          ox <= '0;
          gx <= gx + 11'd1;
        end else begin
          ox <= ox + 7'd1;
        end
      end
    end
  end

  // Latched item and its cell flags.
  logic [PIX_W-1:0] pix_r, pix_g, pix_b;
  logic             keep, first, last, done;
  logic [GX_W-1:0]  addr;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep <= 1'b0;
    end else if (cmd.accept) begin
      keep <= keep_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= s_tdata[7:0];
      pix_g <= s_tdata[15:8];
      pix_b <= s_tdata[23:16];
      first <= first_now;
      last  <= last_now;
      done  <= done_now;
      addr  <= GX_W'(gx);
      col   <= gx[COL_W-1:0];
      row   <= gy[ROW_W-1:0];
    end
  end

  assign status.keep_last = keep && last;

  // Column sums: {luma, blue, green, red}.
  logic [MEM_W-1:0] sum_mem [MAX_FRAME_WIDTH];
  logic [MEM_W-1:0] rd_data;
  logic [WS_W-1:0]  ws;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= sum_mem[addr];
      ws      <= WS_W'(pix_r) * 18'd299 + WS_W'(pix_g) * 18'd587 + WS_W'(pix_b) * 18'd114;
    end
    cnt <= CNT_W'(bw_s) * CNT_W'(bh_s);
  end

  logic [36:0]      lprod;
  logic [7:0]       luma;
  logic [SUM_W-1:0] new_r, new_g, new_b, new_l;

  assign lprod = 37'(ws) * 37'(LUMA_RECIP);
  assign luma  = lprod[LUMA_SHIFT +: 8];

  always_comb begin
    if (first) begin
      new_r = SUM_W'(pix_r);
      new_g = SUM_W'(pix_g);
      new_b = SUM_W'(pix_b);
      new_l = SUM_W'(luma);
    end else begin
      new_r = rd_data[0*SUM_W +: SUM_W] + SUM_W'(pix_r);
      new_g = rd_data[1*SUM_W +: SUM_W] + SUM_W'(pix_g);
      new_b = rd_data[2*SUM_W +: SUM_W] + SUM_W'(pix_b);
      new_l = rd_data[3*SUM_W +: SUM_W] + SUM_W'(luma);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && keep) begin
      sum_mem[addr] <= {new_l, new_b, new_g, new_r};
    end
  end

  // Four restoring dividers in step, one quotient bit per cycle.
  // Lane 0 gives the rounded mean luma, lanes 1 to 3 the floored colour means.
  logic [NUM_W-1:0] div_num [4];
  logic [DEN_W-1:0] div_den [4];
  logic [DEN_W-1:0] div_rem [4];
  logic [DC_W-1:0]  div_cnt;

  assign status.div_last = div_cnt == DC_W'(NUM_W - 1);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num[0] <= NUM_W'({new_l, 1'b0}) + NUM_W'(cnt);
      div_den[0] <= {cnt, 1'b0};
      div_num[1] <= NUM_W'(new_r);
      div_num[2] <= NUM_W'(new_g);
      div_num[3] <= NUM_W'(new_b);
      for (int i = 1; i < 4; i++) begin
        div_den[i] <= DEN_W'(cnt);
      end
      for (int i = 0; i < 4; i++) begin
        div_rem[i] <= '0;
      end
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        logic [DEN_W:0] trial;
        logic           ge;
        trial = {div_rem[i], div_num[i][NUM_W-1]};
        ge    = trial >= {1'b0, div_den[i]};
        div_rem[i] <= ge ? DEN_W'(trial - {1'b0, div_den[i]}) : trial[DEN_W-1:0];
        div_num[i] <= {div_num[i][NUM_W-2:0], ge};
      end
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  // Glyph mapping: index = mean * (GLYPH_COUNT - 1) / 255.
  logic [15:0] gprod;
  logic [32:0] iprod;
  logic [7:0]  idx, lut;

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      gprod <= 16'(div_num[0][7:0]) * 16'(GLYPH_COUNT - 1);
    end
  end

  assign iprod = 33'(gprod) * 33'(DIV255_RECIP);
  assign idx   = iprod[DIV255_SHIFT +: 8];
  assign lut   = (idx > 8'(RAMP_LEN - 1)) ? 8'(RAMP_LEN - 1) : idx;

  // Output register.
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata[9:0]   <= col;
      m_tdata[21:10] <= row;
      m_tdata[28:22] <= idx[GIDX_W-1:0];
      m_tdata[35:29] <= glyph_char(lut);
      m_tdata[43:36] <= color_enable ? div_num[1][7:0] : 8'hFF;
      m_tdata[51:44] <= color_enable ? div_num[2][7:0] : 8'hFF;
      m_tdata[59:52] <= color_enable ? div_num[3][7:0] : 8'hFF;
      m_tdata[63:60] <= '0;
      m_tlast        <= done;
    end
  end

endmodule

// File: design/block_average_ascii_mapper_top.sv
// Block-average ASCII mapper.
// The slave channel takes RGB pixels in raster order. The frame is tiled into
// cells; each completed cell produces one item on the master channel with its
// grid position, glyph index and code, and its mean colour (white when colour
// is off). m_tlast marks the last cell of the frame. Pixels outside the last
// whole cell row or column produce nothing.
// A pixel passes through accept, read of the column-sum memory, and the
// add-and-write back. A pixel that completes a cell then runs the shared
// 24-step restoring dividers, one glyph mapping stage and the output load,
// which waits while the output register is still full; the next pixel is
// taken only after the load.
// The output register holds the result while the receiver stalls; pixels keep
// being accepted, and only a second completed cell waits for the register.
// Reset restores the register defaults (640x480 frame, 8x16 cells, colour
// off) and returns the raster to the frame start. A write to any register
// at index 0 to 4 also returns the raster to the frame start. The sum
// memory needs no clearing: the first pixel of each cell overwrites its entry.
module block_average_ascii_mapper_top #(
  parameter int MAX_FRAME_WIDTH = bam_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_BLOCK_DIM   = bam_pkg::DEF_MAX_BLOCK_DIM,
  parameter int GLYPH_COUNT     = bam_pkg::DEF_GLYPH_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bam_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // red, green, blue
  input  logic [bam_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cell_column, cell_row, glyph_index, glyph_code, mean_red, mean_green,
  // mean_blue, zero fill
  output logic [bam_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tlast
);
  import bam_pkg::*;

  bam_cmd_t    cmd;
  bam_status_t status;

  bam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bam_datapath #(
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
    .MAX_BLOCK_DIM   (MAX_BLOCK_DIM),
    .GLYPH_COUNT     (GLYPH_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: tb/testbench.sv
module testbench;
  import bam_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 960;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [GIDX_W-1:0]  gidx;
    logic [GCODE_W-1:0] gcode;
    logic [PIX_W-1:0]   mr;
    logic [PIX_W-1:0]   mg;
    logic [PIX_W-1:0]   mb;
    logic               done;
  } cell_t;

  typedef struct {
    int          seg;
    logic [7:0]  r, g, b;
    bit          typed;
    bit          has;
    cell_t       target;
  } pixel_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  block_average_ascii_mapper_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block state.
  localparam int MAX_FRAME_WIDTH_TB = 1024;
  int unsigned fr_w, fr_h, blk_w, blk_h, color_on;
  int unsigned ras_x, ras_y;
  int unsigned sum_r[MAX_FRAME_WIDTH_TB], sum_g[MAX_FRAME_WIDTH_TB];
  int unsigned sum_b[MAX_FRAME_WIDTH_TB], sum_y[MAX_FRAME_WIDTH_TB];

  string glyphs = " .'`^,:;Il!i><~+_-?][}{1)(|\\/tfjrxnumbroCLJVUNYXOZmwqpdbkhao*#MW&8%B@$";

  cell_t expected_cells[$];
  int    errors = 0;
  int    pixels_sent = 0;
  int    cells_seen = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    moved;

  function automatic void mirror_reset();
    fr_w = 640; fr_h = 480; blk_w = 8; blk_h = 16; color_on = 0;
    ras_x = 0; ras_y = 0;
    for (int i = 0; i < MAX_FRAME_WIDTH_TB; i++) begin
      sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0; sum_y[i] = 0;
    end
  endfunction

  // Accumulates one pixel and reports the finished cell, if any.
  function automatic bit average_pixel(input logic [7:0] r, g, b, output cell_t c);
    int unsigned bw, bh, x, y, cols, rows, gx, gy, ox, oy, cnt, mean, idx;
    bw = blk_w > 64 ? 64 : blk_w;
    bh = blk_h > 64 ? 64 : blk_h;
    x = ras_x;
    y = ras_y;
    c = '0;
    if (ras_x + 1 >= fr_w) begin
      ras_x = 0;
      if (ras_y + 1 >= fr_h) ras_y = 0;
      else ras_y++;
    end else begin
      ras_x++;
    end
    if (bw == 0 || bh == 0) return 0;
    cols = fr_w / bw;
    if (cols > MAX_FRAME_WIDTH_TB) cols = MAX_FRAME_WIDTH_TB;
    rows = fr_h / bh;
    gx = x / bw;
    gy = y / bh;
    if (gx >= cols || gy >= rows) return 0;
    ox = x - gx * bw;
    oy = y - gy * bh;
    if (ox == 0 && oy == 0) begin
      sum_r[gx] = 0; sum_g[gx] = 0; sum_b[gx] = 0; sum_y[gx] = 0;
    end
    sum_r[gx] += r;
    sum_g[gx] += g;
    sum_b[gx] += b;
    sum_y[gx] += (299 * r + 587 * g + 114 * b) / 1000;
    if (ox + 1 != bw || oy + 1 != bh) return 0;
    cnt = bw * bh;
    mean = (2 * sum_y[gx] + cnt) / (2 * cnt);
    idx = mean * 69 / 255;
    c.col = gx[COL_W-1:0];
    c.row = gy[ROW_W-1:0];
    c.gidx = idx[GIDX_W-1:0];
    c.gcode = GCODE_W'(glyphs[idx > 69 ? 69 : idx]);
    if (color_on != 0) begin
      c.mr = PIX_W'(sum_r[gx] / cnt);
      c.mg = PIX_W'(sum_g[gx] / cnt);
      c.mb = PIX_W'(sum_b[gx] / cnt);
    end else begin
      c.mr = 8'd255; c.mg = 8'd255; c.mb = 8'd255;
    end
    c.done = (gx + 1 == cols && gy + 1 == rows);
    return 1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Waits until every expected cell is out and the pipeline has drained.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx[CFG_IDX_W-1:0])
      REG_FRAME_WIDTH:  fr_w = val & 32'h7FF;
      REG_FRAME_HEIGHT: fr_h = val & 32'h1FFF;
      REG_BLOCK_WIDTH:  blk_w = val & 32'h7F;
      REG_BLOCK_HEIGHT: blk_h = val & 32'h7F;
      REG_COLOR_ENABLE: color_on = val & 1;
      default: return;
    endcase
    ras_x = 0;
    ras_y = 0;
  endtask

  task automatic setup(input int unsigned w, h, bw, bh, col);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BLOCK_WIDTH, bw);
    write_reg(REG_BLOCK_HEIGHT, bh);
    write_reg(REG_COLOR_ENABLE, col);
  endtask

  // Sends one item; a typed row replaces the predicted result with its own.
  task automatic send_pixel(input logic [7:0] r, g, b, input bit typed = 0,
                            input bit has = 0, input cell_t want = '0);
    cell_t c;
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    do @(posedge clk); while (!s_tready);
    hit = average_pixel(r, g, b, c);
    if (typed) begin
      if (has) expected_cells.push_back(want);
    end else if (hit) begin
      expected_cells.push_back(c);
    end
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cell_t got, want;
    moved = (s_tvalid && s_tready) || (m_tvalid && m_tready);
    if (!rst && m_tvalid && m_tready) begin
      got.col = m_tdata[9:0];
      got.row = m_tdata[21:10];
      got.gidx = m_tdata[28:22];
      got.gcode = m_tdata[35:29];
      got.mr = m_tdata[43:36];
      got.mg = m_tdata[51:44];
      got.mb = m_tdata[59:52];
      got.done = m_tlast;
      cells_seen++;
      if (expected_cells.size() == 0) begin
        $error("unexpected cell at column %0d row %0d", got.col, got.row);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_column", want.col, got.col);
        check_field("cell_row", want.row, got.row);
        check_field("glyph_index", want.gidx, got.gidx);
        check_field("glyph_code", want.gcode, got.gcode);
        check_field("mean_red", want.mr, got.mr);
        check_field("mean_green", want.mg, got.mg);
        check_field("mean_blue", want.mb, got.mb);
        check_field("frame_done", want.done, got.done);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Segment 0 runs on the reset registers, 1 on 1x1 cells in colour, 2 on
  // 1x1 cells in white, 3 on 2x2 cells of a 5x3 frame in colour.
  localparam cell_t BLACK_C = '{col: 0, row: 0, gidx: 0, gcode: 7'd32,
                                mr: 0, mg: 0, mb: 0, done: 1};
  localparam cell_t WHITE_C = '{col: 0, row: 0, gidx: 69, gcode: 7'd36,
                                mr: 255, mg: 255, mb: 255, done: 1};
  localparam cell_t DARK_W  = '{col: 0, row: 0, gidx: 0, gcode: 7'd32,
                                mr: 255, mg: 255, mb: 255, done: 1};
  pixel_row_t directed[] = '{
    '{0, 8'd0,   8'd0,   8'd0,   1, 0, '0},
    '{0, 8'd255, 8'd255, 8'd255, 1, 0, '0},
    '{0, 8'd17,  8'd200, 8'd99,  1, 0, '0},
    '{1, 8'd0,   8'd0,   8'd0,   1, 1, BLACK_C},
    '{1, 8'd255, 8'd255, 8'd255, 1, 1, WHITE_C},
    '{1, 8'd255, 8'd0,   8'd0,   0, 0, '0},
    '{1, 8'd0,   8'd255, 8'd0,   0, 0, '0},
    '{1, 8'd0,   8'd0,   8'd255, 0, 0, '0},
    '{1, 8'd128, 8'd64,  8'd32,  0, 0, '0},
    '{2, 8'd0,   8'd0,   8'd0,   1, 1, DARK_W},
    '{2, 8'd255, 8'd255, 8'd255, 1, 1, WHITE_C},
    '{2, 8'd90,  8'd180, 8'd45,  0, 0, '0},
    '{3, 8'd10,  8'd20,  8'd30,  0, 0, '0},
    '{3, 8'd255, 8'd0,   8'd170, 0, 0, '0},
    '{3, 8'd85,  8'd255, 8'd1,   0, 0, '0},
    '{3, 8'd254, 8'd127, 8'd128, 0, 0, '0},
    '{3, 8'd3,   8'd250, 8'd77,  0, 0, '0},
    '{3, 8'd199, 8'd33,  8'd240, 0, 0, '0},
    '{3, 8'd64,  8'd64,  8'd64,  0, 0, '0},
    '{3, 8'd255, 8'd255, 8'd0,   0, 0, '0},
    '{3, 8'd0,   8'd128, 8'd255, 0, 0, '0},
    '{3, 8'd200, 8'd200, 8'd200, 0, 0, '0}
  };

  initial begin
    int seg, rand_sent, phase, n;
    mirror_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    seg = 0;
    foreach (directed[i]) begin
      if (directed[i].seg != seg) begin
        seg = directed[i].seg;
        case (seg)
          1: setup(1, 1, 1, 1, 1);
          2: begin settle(); write_reg(REG_COLOR_ENABLE, 0); end
          default: setup(5, 3, 2, 2, 1);
        endcase
      end
      send_pixel(directed[i].r, directed[i].g, directed[i].b,
                 directed[i].typed, directed[i].has, directed[i].target);
    end

    // Zero-sized registers, oversized cells, a wide frame and a tall frame.
    setup(0, 3, 1, 1, 1);
    repeat (12) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    setup(4, 0, 1, 1, 0);
    repeat (12) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    setup(6, 4, 0, 2, 1);
    repeat (12) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    setup(6, 4, 2, 0, 1);
    repeat (12) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    set_mode(3);
    setup(64, 1, 127, 1, 1);
    repeat (70) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    set_mode(2);
    setup(1, 64, 1, 100, 1);
    repeat (70) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    set_mode(0);
    setup(2047, 2, 64, 1, 1);
    repeat (130) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    setup(1, 8191, 1, 1, 0);
    repeat (20) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      set_mode(phase);
      setup($urandom_range(1, 24), $urandom_range(1, 10),
            ($urandom_range(9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 6),
            ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5), $urandom_range(1));
      n = $urandom_range(30, 90);
      for (int k = 0; k < n; k++) begin
        // An unknown index halfway through must leave the raster alone.
        if (k == n / 2 && phase % 3 == 0) begin
          settle();
          write_reg($urandom_range(5, 7), $urandom_range(8191));
        end
        send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
      rand_sent += n;
      phase++;
    end

    settle();
    $display("Sent %0d pixels over %0d random phases plus directed and corner cases;",
             pixels_sent, phase);
    $display("checked %0d cells against the predicted averages and glyphs.", cells_seen);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
